// ===== rtl/uas_pkg.sv =====
// Package: shared widths, action and status codes, and defaults for the adjacency store.
`timescale 1ns / 1ps
package uas_pkg;

    // Field widths fixed by the stream format
    localparam int NODE_W    = 10;
    localparam int ACT_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int DEG_OUT_W = 7;
    localparam int EDGE_W    = 16;
    localparam int SHARE_W   = 17;
    localparam int FRAC_W    = 16;

    // Stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    // Defaults for the top-level parameters
    localparam int NODES_DEF      = 1024;
    localparam int MAX_DEGREE_DEF = 64;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ADD      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REM_EDGE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REM_NODE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STATS    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ONE_SIDE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Largest share value, 1.0 in Q1.16
    localparam logic [SHARE_W-1:0] SHARE_MAX = 17'h10000;

endpackage

// ===== rtl/uas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module uas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/uas_div.sv =====
// Serial restoring divider, one quotient bit per cycle, for the attachment shares.
`timescale 1ns / 1ps
module uas_div
    import uas_pkg::*;
#(
    parameter int DVD_W = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [EDGE_W:0]  divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [EDGE_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [EDGE_W:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [EDGE_W+1:0] trial;
    logic [EDGE_W+1:0] diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // One shift-subtract step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[EDGE_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[EDGE_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/undirected_adjacency_store_core.sv =====
// Top level: undirected graph store with neighbor-list RAM, degree RAM and action sequencer.
// One action at a time; remove edge searches and erases in both lists, remove node does
//   one find and erase per neighbor, and stats scans every degree RAM entry. The walk
//   through the single-read neighbor RAM and the bit-serial share divider set the run time.
// Reset: asynchronous, active low; then a clear pass zeroes every degree RAM entry
//   with s_axis_tready low. Neighbor lists are not cleared.
`timescale 1ns / 1ps
module undirected_adjacency_store_core
    import uas_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // node_a, node_b, zero pad
    input  logic [ACT_W-1:0]       s_axis_tuser,   // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // degree_a, degree_b, edge_count,
                                                   // share_a, share_b, max_degree,
                                                   // min_degree, zero pad
    output logic [STATUS_W-1:0]    m_axis_tuser    // status
);

    localparam int NW   = $clog2(NODES);
    localparam int DEGW = $clog2(MAX_DEGREE + 1);
    localparam int AW   = $clog2(NODES * MAX_DEGREE);
    localparam int QW   = DEGW + FRAC_W;

    // Sequencer states
    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_GDEG   = 5'd2;
    localparam logic [4:0] S_GDEG_W = 5'd3;
    localparam logic [4:0] S_FRD    = 5'd4;
    localparam logic [4:0] S_FCMP   = 5'd5;
    localparam logic [4:0] S_ERD    = 5'd6;
    localparam logic [4:0] S_EWR    = 5'd7;
    localparam logic [4:0] S_EDEG   = 5'd8;
    localparam logic [4:0] S_NEXT   = 5'd9;
    localparam logic [4:0] S_AW1    = 5'd10;
    localparam logic [4:0] S_AW2    = 5'd11;
    localparam logic [4:0] S_AD1    = 5'd12;
    localparam logic [4:0] S_AD2    = 5'd13;
    localparam logic [4:0] S_RNW    = 5'd14;
    localparam logic [4:0] S_SCAN   = 5'd15;
    localparam logic [4:0] S_SLAST  = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;
    localparam logic [4:0] S_FIN2   = 5'd18;
    localparam logic [4:0] S_FIN3   = 5'd19;
    localparam logic [4:0] S_DIVA   = 5'd20;
    localparam logic [4:0] S_DIVB   = 5'd21;
    localparam logic [4:0] S_OUT    = 5'd22;

    // Steps within one action
    localparam logic [2:0] PH_BEGIN  = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_SECOND = 3'd2;
    localparam logic [2:0] PH_THIRD  = 3'd3;
    localparam logic [2:0] PH_FOURTH = 3'd4;
    localparam logic [2:0] PH_FINAL  = 3'd5;

    logic [4:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic                va_reg, va_next;
    logic                vb_reg, vb_next;
    logic [NODE_W-1:0]   own_reg, own_next;
    logic [NODE_W-1:0]   key_reg, key_next;
    logic                srch_reg, srch_next;
    logic [DEGW-1:0]     odeg_reg, odeg_next;
    logic [DEGW-1:0]     dsave_reg, dsave_next;
    logic [DEGW-1:0]     k_reg, k_next;
    logic                found_reg, found_next;
    logic [1:0]          hits_reg, hits_next;
    logic                missed_reg, missed_next;
    logic [DEGW-1:0]     loops_reg, loops_next;
    logic [DEGW-1:0]     rk_reg, rk_next;
    logic [DEGW-1:0]     rdeg_reg, rdeg_next;
    logic [NODE_W-1:0]   nval_reg, nval_next;
    logic [EDGE_W-1:0]   edges_reg, edges_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DEGW-1:0]     maxd_reg, maxd_next;
    logic [DEGW-1:0]     mind_reg, mind_next;
    logic [NW-1:0]       si_reg, si_next;
    logic                pv_reg, pv_next;
    logic [DEGW-1:0]     da_reg, da_next;
    logic [DEGW-1:0]     db_reg, db_next;
    logic [SHARE_W-1:0]  sha_reg, sha_next;
    logic [SHARE_W-1:0]  shb_reg, shb_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [STATUS_W-1:0] m_user_reg, m_user_next;

    // RAM ports
    logic              nb_we;
    logic [AW-1:0]     nb_waddr, nb_raddr;
    logic [NODE_W-1:0] nb_wdata, nb_rdata;
    logic              dg_we;
    logic [NW-1:0]     dg_waddr, dg_raddr;
    logic [DEGW-1:0]   dg_wdata, dg_rdata;

    // Divider
    logic              div_start, div_done;
    logic [QW-1:0]     div_dvd, div_q;
    logic [EDGE_W:0]   div_dvs;

    logic              in_va, in_vb;
    logic [DEGW-1:0]   half_loops;

    // Address of entry k in a node's list
    function automatic logic [AW-1:0] slot(input logic [NODE_W-1:0] node,
                                           input logic [DEGW-1:0] k);
        return AW'(node) * AW'(MAX_DEGREE) + AW'(k);
    endfunction

    // Degree saturated to the output field
    function automatic logic [DEG_OUT_W-1:0] deg7(input logic [DEGW-1:0] d);
        logic [DEGW+DEG_OUT_W-1:0] w;
        w = (DEGW+DEG_OUT_W)'(d);
        return (w > (DEGW+DEG_OUT_W)'(127)) ? DEG_OUT_W'(127) : DEG_OUT_W'(w);
    endfunction

    // Quotient capped at 1.0
    function automatic logic [SHARE_W-1:0] cap_share(input logic [QW-1:0] q);
        return (q > QW'(SHARE_MAX)) ? SHARE_MAX : SHARE_W'(q);
    endfunction

    uas_ram #(
        .WIDTH(NODE_W),
        .DEPTH(NODES * MAX_DEGREE)
    ) u_nbr_ram (
        .clk   (clk),
        .we    (nb_we),
        .waddr (nb_waddr),
        .wdata (nb_wdata),
        .raddr (nb_raddr),
        .rdata (nb_rdata)
    );

    uas_ram #(
        .WIDTH(DEGW),
        .DEPTH(NODES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (dg_we),
        .waddr (dg_waddr),
        .wdata (dg_wdata),
        .raddr (dg_raddr),
        .rdata (dg_rdata)
    );

    uas_div #(
        .DVD_W(QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_va      = 32'(s_axis_tdata[NODE_W-1:0]) < NODES;
    assign in_vb      = 32'(s_axis_tdata[2*NODE_W-1:NODE_W]) < NODES;
    assign half_loops = loops_reg >> 1;
    assign div_dvs    = {edges_reg, 1'b0};
    assign div_dvd    = (state_reg == S_DIVA) ? {db_reg, FRAC_W'(0)} : {da_reg, FRAC_W'(0)};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Action sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        act_next     = act_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        own_next     = own_reg;
        key_next     = key_reg;
        srch_next    = srch_reg;
        odeg_next    = odeg_reg;
        dsave_next   = dsave_reg;
        k_next       = k_reg;
        found_next   = found_reg;
        hits_next    = hits_reg;
        missed_next  = missed_reg;
        loops_next   = loops_reg;
        rk_next      = rk_reg;
        rdeg_next    = rdeg_reg;
        nval_next    = nval_reg;
        edges_next   = edges_reg;
        status_next  = status_reg;
        maxd_next    = maxd_reg;
        mind_next    = mind_reg;
        si_next      = si_reg;
        pv_next      = (state_reg == S_SCAN);
        da_next      = da_reg;
        db_next      = db_reg;
        sha_next     = sha_reg;
        shb_next     = shb_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        nb_we        = 1'b0;
        nb_waddr     = '0;
        nb_wdata     = '0;
        nb_raddr     = '0;
        dg_we        = 1'b0;
        dg_waddr     = '0;
        dg_wdata     = '0;
        dg_raddr     = '0;
        div_start    = 1'b0;

        // Degree scan data arrives in the cycle after its read
        if (pv_reg)
        begin
            if (dg_rdata > maxd_reg)
            begin
                maxd_next = dg_rdata;
            end
            if ((dg_rdata != '0) && ((mind_reg == '0) || (dg_rdata < mind_reg)))
            begin
                mind_next = dg_rdata;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                dg_we    = 1'b1;
                dg_waddr = si_reg;
                si_next  = si_reg + 1'b1;
                if (si_reg == NW'(NODES - 1))
                begin
                    si_next    = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next    = s_axis_tuser;
                    a_next      = s_axis_tdata[NODE_W-1:0];
                    b_next      = s_axis_tdata[2*NODE_W-1:NODE_W];
                    va_next     = in_va;
                    vb_next     = in_vb;
                    phase_next  = PH_BEGIN;
                    status_next = ST_OK;
                    hits_next   = '0;
                    missed_next = 1'b0;
                    loops_next  = '0;
                    maxd_next   = '0;
                    mind_next   = '0;
                    si_next     = '0;
                    state_next  = S_NEXT;
                end
            end
            // Degree fetch, optionally followed by a list search
            S_GDEG:
            begin
                dg_raddr   = NW'(own_reg);
                state_next = S_GDEG_W;
            end
            S_GDEG_W:
            begin
                odeg_next  = dg_rdata;
                k_next     = '0;
                found_next = 1'b0;
                state_next = srch_reg ? S_FRD : S_NEXT;
            end
            S_FRD:
            begin
                if (k_reg >= odeg_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    nb_raddr   = slot(own_reg, k_reg);
                    state_next = S_FCMP;
                end
            end
            S_FCMP:
            begin
                if (nb_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            // Erase entry k: shift the tail down one place
            S_ERD:
            begin
                if (({1'b0, k_reg} + 1'b1) < {1'b0, odeg_reg})
                begin
                    nb_raddr   = slot(own_reg, k_reg + 1'b1);
                    state_next = S_EWR;
                end
                else
                begin
                    state_next = S_EDEG;
                end
            end
            S_EWR:
            begin
                nb_we      = 1'b1;
                nb_waddr   = slot(own_reg, k_reg);
                nb_wdata   = nb_rdata;
                k_next     = k_reg + 1'b1;
                state_next = S_ERD;
            end
            S_EDEG:
            begin
                dg_we      = 1'b1;
                dg_waddr   = NW'(own_reg);
                dg_wdata   = odeg_reg - 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        unique case (phase_reg)
                            PH_BEGIN:
                            begin
                                if (!(va_reg && vb_reg))
                                begin
                                    status_next = ST_NOT_FOUND;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    own_next   = a_reg;
                                    key_next   = b_reg;
                                    srch_next  = 1'b1;
                                    phase_next = PH_FIRST;
                                    state_next = S_GDEG;
                                end
                            end
                            PH_FIRST:
                            begin
                                if (found_reg)
                                begin
                                    status_next = ST_DUP;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    dsave_next = odeg_reg;
                                    own_next   = b_reg;
                                    srch_next  = 1'b0;
                                    phase_next = PH_SECOND;
                                    state_next = S_GDEG;
                                end
                            end
                            default:
                            begin
                                // dsave holds deg(a), odeg holds deg(b)
                                if ((a_reg == b_reg) ?
                                    (({1'b0, dsave_reg} + 2'd2) > (DEGW+1)'(MAX_DEGREE)) :
                                    ((({1'b0, dsave_reg} + 1'b1) > (DEGW+1)'(MAX_DEGREE)) ||
                                     (({1'b0, odeg_reg} + 1'b1) > (DEGW+1)'(MAX_DEGREE))))
                                begin
                                    status_next = ST_FULL;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    state_next = S_AW1;
                                end
                            end
                        endcase
                    end
                    ACT_REM_EDGE:
                    begin
                        unique case (phase_reg)
                            PH_BEGIN:
                            begin
                                if (!(va_reg && vb_reg))
                                begin
                                    status_next = ST_NOT_FOUND;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    own_next   = a_reg;
                                    key_next   = b_reg;
                                    srch_next  = 1'b1;
                                    phase_next = PH_FIRST;
                                    state_next = S_GDEG;
                                end
                            end
                            PH_FIRST, PH_THIRD:
                            begin
                                phase_next = phase_reg + 1'b1;
                                if (found_reg)
                                begin
                                    hits_next  = hits_reg + 1'b1;
                                    state_next = S_ERD;
                                end
                            end
                            PH_SECOND:
                            begin
                                own_next   = b_reg;
                                key_next   = a_reg;
                                srch_next  = 1'b1;
                                phase_next = PH_THIRD;
                                state_next = S_GDEG;
                            end
                            default:
                            begin
                                if (hits_reg == 2'd0)
                                begin
                                    status_next = ST_NOT_FOUND;
                                end
                                else
                                begin
                                    status_next = (hits_reg == 2'd1) ? ST_ONE_SIDE : ST_OK;
                                    edges_next  = (edges_reg != '0) ? edges_reg - 1'b1 : '0;
                                end
                                state_next = S_FIN;
                            end
                        endcase
                    end
                    ACT_REM_NODE:
                    begin
                        unique case (phase_reg)
                            PH_BEGIN:
                            begin
                                if (!va_reg)
                                begin
                                    status_next = ST_NOT_FOUND;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    own_next   = a_reg;
                                    srch_next  = 1'b0;
                                    phase_next = PH_FIRST;
                                    state_next = S_GDEG;
                                end
                            end
                            PH_FIRST:
                            begin
                                rdeg_next  = odeg_reg;
                                rk_next    = '0;
                                phase_next = PH_SECOND;
                            end
                            PH_SECOND:
                            begin
                                if (rk_reg >= rdeg_reg)
                                begin
                                    phase_next = PH_FINAL;
                                end
                                else
                                begin
                                    nb_raddr   = slot(a_reg, rk_reg);
                                    state_next = S_RNW;
                                end
                            end
                            PH_THIRD:
                            begin
                                if (nval_reg == a_reg)
                                begin
                                    // self loop entry, counted later
                                    loops_next = loops_reg + 1'b1;
                                    rk_next    = rk_reg + 1'b1;
                                    phase_next = PH_SECOND;
                                end
                                else if (32'(nval_reg) < NODES)
                                begin
                                    own_next   = nval_reg;
                                    key_next   = a_reg;
                                    srch_next  = 1'b1;
                                    phase_next = PH_FOURTH;
                                    state_next = S_GDEG;
                                end
                                else
                                begin
                                    edges_next = (edges_reg != '0) ? edges_reg - 1'b1 : '0;
                                    rk_next    = rk_reg + 1'b1;
                                    phase_next = PH_SECOND;
                                end
                            end
                            PH_FOURTH:
                            begin
                                edges_next = (edges_reg != '0) ? edges_reg - 1'b1 : '0;
                                rk_next    = rk_reg + 1'b1;
                                phase_next = PH_SECOND;
                                if (found_reg)
                                begin
                                    state_next = S_ERD;
                                end
                                else
                                begin
                                    missed_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (EDGE_W'(half_loops) >= edges_reg)
                                begin
                                    edges_next = '0;
                                end
                                else
                                begin
                                    edges_next = edges_reg - EDGE_W'(half_loops);
                                end
                                dg_we       = 1'b1;
                                dg_waddr    = NW'(a_reg);
                                dg_wdata    = '0;
                                status_next = missed_reg ? ST_ONE_SIDE : ST_OK;
                                state_next  = S_FIN;
                            end
                        endcase
                    end
                    default:
                    begin
                        si_next    = '0;
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_RNW:
            begin
                nval_next  = nb_rdata;
                phase_next = PH_THIRD;
                state_next = S_NEXT;
            end
            // Add: append both directions, then bump degrees
            S_AW1:
            begin
                nb_we      = 1'b1;
                nb_waddr   = slot(a_reg, dsave_reg);
                nb_wdata   = b_reg;
                state_next = S_AW2;
            end
            S_AW2:
            begin
                nb_we    = 1'b1;
                nb_wdata = a_reg;
                if (a_reg == b_reg)
                begin
                    nb_waddr = slot(a_reg, dsave_reg + 1'b1);
                end
                else
                begin
                    nb_waddr = slot(b_reg, odeg_reg);
                end
                state_next = S_AD1;
            end
            S_AD1:
            begin
                dg_we      = 1'b1;
                dg_waddr   = NW'(a_reg);
                dg_wdata   = (a_reg == b_reg) ? dsave_reg + 2'd2 : dsave_reg + 1'b1;
                state_next = S_AD2;
            end
            S_AD2:
            begin
                if (a_reg != b_reg)
                begin
                    dg_we    = 1'b1;
                    dg_waddr = NW'(b_reg);
                    dg_wdata = odeg_reg + 1'b1;
                end
                if (edges_reg != {EDGE_W{1'b1}})
                begin
                    edges_next = edges_reg + 1'b1;
                end
                state_next = S_FIN;
            end
            // Statistics scan over the degree RAM
            S_SCAN:
            begin
                dg_raddr = si_reg;
                si_next  = si_reg + 1'b1;
                if (si_reg == NW'(NODES - 1))
                begin
                    state_next = S_SLAST;
                end
            end
            S_SLAST:
            begin
                state_next = S_FIN;
            end
            // Final degrees and shares
            S_FIN:
            begin
                dg_raddr   = NW'(a_reg);
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                dg_raddr   = NW'(b_reg);
                da_next    = va_reg ? dg_rdata : '0;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                db_next = vb_reg ? dg_rdata : '0;
                if (edges_reg == '0)
                begin
                    sha_next   = '0;
                    shb_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVA;
                end
            end
            S_DIVA:
            begin
                if (div_done)
                begin
                    sha_next   = cap_share(div_q);
                    div_start  = 1'b1;
                    state_next = S_DIVB;
                end
            end
            S_DIVB:
            begin
                if (div_done)
                begin
                    shb_next   = cap_share(div_q);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {2'b00, deg7(mind_reg), deg7(maxd_reg), shb_reg, sha_reg,
                                    edges_reg, deg7(db_reg), deg7(da_reg)};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            phase_reg   <= PH_BEGIN;
            si_reg      <= '0;
            pv_reg      <= 1'b0;
            edges_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            si_reg      <= si_next;
            pv_reg      <= pv_next;
            edges_reg   <= edges_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        own_reg    <= own_next;
        key_reg    <= key_next;
        srch_reg   <= srch_next;
        odeg_reg   <= odeg_next;
        dsave_reg  <= dsave_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        hits_reg   <= hits_next;
        missed_reg <= missed_next;
        loops_reg  <= loops_next;
        rk_reg     <= rk_next;
        rdeg_reg   <= rdeg_next;
        nval_reg   <= nval_next;
        status_reg <= status_next;
        maxd_reg   <= maxd_next;
        mind_reg   <= mind_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        sha_reg    <= sha_next;
        shb_reg    <= shb_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Edge count moves only while an action is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(edges_reg))
        else $error("edge count changed outside an action");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIVA) || (state_reg == S_DIVB)))
        else $error("divider result arrived unexpectedly");

    // List compare never reads past the list's degree
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCMP) |-> (k_reg < odeg_reg))
        else $error("neighbor search beyond list end");

endmodule

// ===== tb/undirected_adjacency_store_core_tb.sv =====
// Testbench: random and directed graph actions checked against an in-bench model of the store.
`timescale 1ns / 1ps
module undirected_adjacency_store_core_tb;
    import uas_pkg::*;

    localparam int N_NODES = NODES_DEF;
    localparam int MAXDEG  = MAX_DEGREE_DEF;
    localparam int N_ITEMS = 1750;
    localparam longint CYCLE_LIMIT = 150000000;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [DEG_OUT_W-1:0] deg_a;
        logic [DEG_OUT_W-1:0] deg_b;
        logic [EDGE_W-1:0]    edges;
        logic [SHARE_W-1:0]   share_a;
        logic [SHARE_W-1:0]   share_b;
        logic [DEG_OUT_W-1:0] max_deg;
        logic [DEG_OUT_W-1:0] min_deg;
    } graph_result_t;

    // Graph model and queue of expected results
    class graph_scoreboard;
        int unsigned nbr[N_NODES][MAXDEG];
        int unsigned deg[N_NODES];
        int unsigned edge_cnt;
        graph_result_t pending[$];
        int errors;

        function new();
            foreach (deg[i]) deg[i] = 0;
            edge_cnt = 0;
            errors = 0;
        endfunction

        function int find_nbr(int unsigned n, int unsigned v);
            for (int k = 0; k < deg[n]; k++)
                if (nbr[n][k] == v) return k;
            return -1;
        endfunction

        function void erase_nbr(int unsigned n, int unsigned idx);
            for (int unsigned k = idx; k + 1 < deg[n]; k++) nbr[n][k] = nbr[n][k+1];
            if (deg[n] > 0) deg[n]--;
        endfunction

        function void drop_edge();
            if (edge_cnt > 0) edge_cnt--;
        endfunction

        function logic [SHARE_W-1:0] share_of(int unsigned d);
            longint unsigned q;
            if (edge_cnt == 0) return '0;
            q = (longint'(d) << FRAC_W) / (2 * longint'(edge_cnt));
            return (q > 65536) ? SHARE_MAX : q[SHARE_W-1:0];
        endfunction

        // Apply one accepted action and queue its result
        function void note_input(logic [ACT_W-1:0] act, int unsigned a, int unsigned b);
            graph_result_t r;
            int unsigned hits, loops, mx, mn, n;
            int i;
            bit missed;
            r = '0;
            r.status = ST_OK;
            mx = 0;
            mn = 0;
            case (act)
                ACT_ADD:
                begin
                    if (find_nbr(a, b) >= 0) r.status = ST_DUP;
                    else if ((a == b && deg[a] + 2 > MAXDEG) ||
                             (a != b && (deg[a] + 1 > MAXDEG || deg[b] + 1 > MAXDEG)))
                        r.status = ST_FULL;
                    else
                    begin
                        nbr[a][deg[a]] = b; deg[a]++;
                        nbr[b][deg[b]] = a; deg[b]++;
                        if (edge_cnt < 16'hFFFF) edge_cnt++;
                    end
                end
                ACT_REM_EDGE:
                begin
                    hits = 0;
                    i = find_nbr(a, b);
                    if (i >= 0) begin erase_nbr(a, i); hits++; end
                    i = find_nbr(b, a);
                    if (i >= 0) begin erase_nbr(b, i); hits++; end
                    if (hits == 0) r.status = ST_NOT_FOUND;
                    else
                    begin
                        r.status = (hits == 1) ? ST_ONE_SIDE : ST_OK;
                        drop_edge();
                    end
                end
                ACT_REM_NODE:
                begin
                    loops = 0;
                    missed = 0;
                    for (int k = 0; k < deg[a]; k++)
                    begin
                        n = nbr[a][k];
                        if (n == a) loops++;
                        else
                        begin
                            i = find_nbr(n, a);
                            if (i >= 0) erase_nbr(n, i);
                            else missed = 1;
                            drop_edge();
                        end
                    end
                    for (int k = 0; k < loops / 2; k++) drop_edge();
                    deg[a] = 0;
                    r.status = missed ? ST_ONE_SIDE : ST_OK;
                end
                default:
                begin
                    foreach (deg[k])
                    begin
                        if (deg[k] > mx) mx = deg[k];
                        if (deg[k] > 0 && (mn == 0 || deg[k] < mn)) mn = deg[k];
                    end
                end
            endcase
            r.deg_a   = DEG_OUT_W'(deg[a]);
            r.deg_b   = DEG_OUT_W'(deg[b]);
            r.edges   = EDGE_W'(edge_cnt);
            r.share_a = share_of(deg[a]);
            r.share_b = share_of(deg[b]);
            r.max_deg = DEG_OUT_W'(mx);
            r.min_deg = DEG_OUT_W'(mn);
            pending = {pending, r};
        endfunction

        function void check_result(graph_result_t got);
            graph_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [ACT_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    graph_scoreboard sb = new();
    longint cycles = 0;
    bit calm = 0;
    bit hold_off = 0;
    int active[$];

    always #2 clk = ~clk;

    undirected_adjacency_store_core i_dut (.*);

    // Result side: random stall, long hold-off on request
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result({m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[13:7],
                m_axis_tdata[29:14], m_axis_tdata[46:30], m_axis_tdata[63:47],
                m_axis_tdata[70:64], m_axis_tdata[77:71]});
        m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 9);
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Drive one transaction and note it on acceptance; valid stays up for the next one
    task automatic send_action(logic [ACT_W-1:0] act, int unsigned a, int unsigned b);
        while (!calm && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'b0, b[9:0], a[9:0]};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(act, a, b);
    endtask

    function automatic int unsigned pick_node();
        if (active.size() > 0 && $urandom_range(3) != 0)
            return active[$urandom_range(active.size() - 1)];
        return $urandom_range(N_NODES - 1);
    endfunction

    initial
    begin
        int unsigned a, b, r;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty stats, extremes, self loop, duplicate, one full list
        send_action(ACT_STATS, 0, 1023);
        send_action(ACT_ADD, 0, 1023);
        send_action(ACT_ADD, 0, 1023);
        send_action(ACT_ADD, 1023, 0);
        send_action(ACT_ADD, 5, 5);
        send_action(ACT_STATS, 5, 0);
        send_action(ACT_REM_EDGE, 5, 5);
        send_action(ACT_REM_EDGE, 5, 5);
        send_action(ACT_REM_EDGE, 1023, 0);
        send_action(ACT_ADD, 682, 341);
        send_action(ACT_REM_NODE, 341, 682);
        send_action(ACT_REM_NODE, 1023, 0);
        for (int k = 0; k < MAXDEG; k++) send_action(ACT_ADD, 7, 100 + k);
        send_action(ACT_ADD, 7, 300);
        send_action(ACT_ADD, 7, 7);
        send_action(ACT_STATS, 0, 0);
        send_action(ACT_REM_NODE, 7, 100);
        send_action(ACT_STATS, 0, 0);

        // Random: a small pool of active nodes builds dense lists
        for (int k = 0; k < 40; k++) active = {active, int'($urandom_range(N_NODES - 1))};
        active = {active, 0};
        active = {active, 1023};
        for (int k = 0; k < N_ITEMS; k++)
        begin
            calm = (k >= 400 && k < 700);
            if (k == 900)
                fork
                begin
                    hold_off = 1;
                    repeat (3000) @(posedge clk);
                    hold_off = 0;
                end
                join_none
            a = pick_node();
            b = ($urandom_range(19) == 0) ? a : pick_node();
            r = $urandom_range(99);
            if (r < 55) send_action(ACT_ADD, a, b);
            else if (r < 80) send_action(ACT_REM_EDGE, a, b);
            else if (r < 90) send_action(ACT_REM_NODE, a, b);
            else send_action(ACT_STATS, a, b);
        end
        s_axis_tvalid <= 0;
        calm = 0;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
